@@ sv/jps_pkg.sv @@
// ============================================================================
// jps_pkg: shared types, codes and fixed-point helpers
// Transfer payload types, command and register codes, the controller's
// states and saturating 64-bit arithmetic used by the Jacobi grid solver.
// ============================================================================
package jps_pkg;

    localparam int GRID_SIDE_DEF   = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int RES_W      = 48;
    localparam int SIDE_W     = 7;
    localparam int SWEEP_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [RES_W-1:0]   RES_MAX      = '1;
    localparam logic [SIDE_W-1:0]  SIDE_RST     = 7'd64;
    localparam logic [RES_W-1:0]   TOL_RST      = 48'd26844;
    localparam logic [SWEEP_W-1:0] MAX_SW_RST   = 16'hFFFF;
    localparam logic [SIDE_W-1:0]  SIDE_MIN     = 7'd3;

    // Item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        point_index;
        logic signed [31:0] start_value;
        logic signed [31:0] source_term;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [15:0]        sweeps_done;
        logic               converged;
        logic [47:0]        residual;
    } t_out_item;

    // Position flags of one streamed read during a sweep.
    typedef struct packed {
        logic vld;        // a grid read is issued this cycle
        logic row_pre;    // read row 0: no centre point yet
        logic row_top;    // centre point lies in the top row
        logic row_bot;    // centre point lies in the bottom row
        logic col_first;  // centre point lies in the left column
        logic col_last;   // centre point lies in the right column
    } t_pos;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // Clamp to the two's complement range from -hi-1 up to hi.
    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] hi);
        logic signed [63:0] lo;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

@@ sv/jps_ram.sv @@
// ============================================================================
// jps_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ============================================================================
module jps_ram #(
    parameter int DEPTH = jps_pkg::GRID_SIDE_DEF,
    parameter int WIDTH = jps_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/jps_stencil.sv @@
// ============================================================================
// jps_stencil: streaming 5-point stencil datapath
// Builds the stencil window from the streamed old copy and two row buffers,
// computes the new value, emits the write-back and accumulates the L1 change.
// ============================================================================
module jps_stencil #(
    parameter int GRID_SIDE   = jps_pkg::GRID_SIDE_DEF,
    parameter int VALUE_WIDTH = jps_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  jps_pkg::t_pos                            i_pos,
    input  logic [$clog2(GRID_SIDE)-1:0]             i_col,
    input  logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]   i_paddr,
    input  logic                                     i_sel,
    input  logic [2*VALUE_WIDTH-1:0]                 i_grid_rdata,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]   o_src_raddr,
    input  logic [VALUE_WIDTH-1:0]                   i_src_rdata,
    output logic                                     o_wr_en,
    output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]   o_wr_addr,
    output logic [2*VALUE_WIDTH-1:0]                 o_wr_data,
    output logic                                     o_busy,
    output logic [jps_pkg::RES_W-1:0]                o_residual
);

    import jps_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int CW = $clog2(GRID_SIDE);
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;

    // Stage S1: grid and row buffer data arrive
    t_pos                 r_s1_pos;
    logic [CW-1:0]        r_s1_col;
    logic [AW-1:0]        r_s1_paddr;
    logic signed [VW-1:0] w_old_q;
    logic [VW-1:0]        w_mid_q;
    logic [VW-1:0]        w_top_q;

    // Window stages A (right neighbour), B (centre), C (left neighbour)
    logic                 r_a_vld, r_a_bnd, r_b_vld, r_b_bnd;
    logic [AW-1:0]        r_a_paddr, r_b_paddr;
    logic signed [VW-1:0] r_a_up, r_a_ctr, r_a_dn;
    logic signed [VW-1:0] r_b_up, r_b_ctr, r_b_dn, r_c_ctr;

    // Arithmetic stages
    logic                 r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld, r_p6_vld;
    logic                 r_p1_bnd, r_p2_bnd, r_p3_bnd, r_p4_bnd;
    logic [AW-1:0]        r_p1_paddr, r_p2_paddr, r_p3_paddr, r_p4_paddr, r_p5_paddr;
    logic signed [VW-1:0] r_p1_ctr, r_p2_ctr, r_p3_ctr, r_p4_ctr;
    logic signed [VW-1:0] r_p1_up, r_p2_up, r_p1_dn;
    logic signed [VW-1:0] r_p1_src, r_p2_src, r_p3_src;
    logic signed [63:0]   r_p1_s, r_p2_s, r_p3_s, r_p4_s;
    logic signed [VW-1:0] r_p5_old, r_p5_new;
    logic [63:0]          r_p6_ad;
    logic [RES_W-1:0]     r_acc;

    logic signed [63:0]   w_t, w_q, w_d;
    logic signed [VW-1:0] w_new;
    logic [63:0]          w_du, w_ad;

    assign w_old_q = i_sel ? i_grid_rdata[2*VW-1:VW] : i_grid_rdata[VW-1:0];

    // Row buffers: mid holds the row above the read row, top the row above that.
    jps_ram #(.DEPTH(GRID_SIDE), .WIDTH(VW)) u_lb_mid (
        .i_clk   (i_clk),
        .i_we    (r_s1_pos.vld),
        .i_waddr (r_s1_col),
        .i_wdata (w_old_q),
        .i_raddr (i_col),
        .o_rdata (w_mid_q)
    );

    jps_ram #(.DEPTH(GRID_SIDE), .WIDTH(VW)) u_lb_top (
        .i_clk   (i_clk),
        .i_we    (r_s1_pos.vld),
        .i_waddr (r_s1_col),
        .i_wdata (w_mid_q),
        .i_raddr (i_col),
        .o_rdata (w_top_q)
    );

    assign o_src_raddr = r_a_paddr;

    always_comb begin
        w_t   = sat_add64(r_p4_s, 64'sd2);
        w_q   = w_t >>> 2;
        w_new = r_p4_bnd ? r_p4_ctr : VW'(clamp64(w_q, VMAX));
        w_d   = sat_sub64(64'(r_p5_new), 64'(r_p5_old));
        w_du  = w_d;
        w_ad  = w_d[63] ? (~w_du + 64'd1) : w_du;
    end

    // Valid bits and the accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pos <= '0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_p5_vld <= 1'b0;
            r_p6_vld <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_s1_pos <= i_pos;
            r_a_vld  <= r_s1_pos.vld && !r_s1_pos.row_pre;
            r_b_vld  <= r_a_vld;
            r_p1_vld <= r_b_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
            r_p5_vld <= r_p4_vld;
            r_p6_vld <= r_p5_vld;
            if (i_start) begin
                r_acc <= '0;
            end else if (r_p6_vld) begin
                if (r_p6_ad >= 64'(RES_MAX - r_acc)) begin
                    r_acc <= RES_MAX;
                end else begin
                    r_acc <= r_acc + RES_W'(r_p6_ad);
                end
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        r_s1_col   <= i_col;
        r_s1_paddr <= i_paddr;

        r_a_bnd   <= r_s1_pos.row_top || r_s1_pos.row_bot ||
                     r_s1_pos.col_first || r_s1_pos.col_last;
        r_a_paddr <= r_s1_paddr;
        r_a_up    <= w_top_q;
        r_a_ctr   <= w_mid_q;
        r_a_dn    <= w_old_q;

        r_b_bnd   <= r_a_bnd;
        r_b_paddr <= r_a_paddr;
        r_b_up    <= r_a_up;
        r_b_ctr   <= r_a_ctr;
        r_b_dn    <= r_a_dn;
        r_c_ctr   <= r_b_ctr;

        // Same order of saturating steps as the defining arithmetic:
        // right plus left, then down, then up, then minus the source.
        r_p1_bnd   <= r_b_bnd;
        r_p1_paddr <= r_b_paddr;
        r_p1_ctr   <= r_b_ctr;
        r_p1_up    <= r_b_up;
        r_p1_dn    <= r_b_dn;
        r_p1_src   <= i_src_rdata;
        r_p1_s     <= sat_add64(64'(r_a_ctr), 64'(r_c_ctr));

        r_p2_bnd   <= r_p1_bnd;
        r_p2_paddr <= r_p1_paddr;
        r_p2_ctr   <= r_p1_ctr;
        r_p2_up    <= r_p1_up;
        r_p2_src   <= r_p1_src;
        r_p2_s     <= sat_add64(r_p1_s, 64'(r_p1_dn));

        r_p3_bnd   <= r_p2_bnd;
        r_p3_paddr <= r_p2_paddr;
        r_p3_ctr   <= r_p2_ctr;
        r_p3_src   <= r_p2_src;
        r_p3_s     <= sat_add64(r_p2_s, 64'(r_p2_up));

        r_p4_bnd   <= r_p3_bnd;
        r_p4_paddr <= r_p3_paddr;
        r_p4_ctr   <= r_p3_ctr;
        r_p4_s     <= sat_sub64(r_p3_s, 64'(r_p3_src));

        r_p5_paddr <= r_p4_paddr;
        r_p5_old   <= r_p4_ctr;
        r_p5_new   <= w_new;

        r_p6_ad    <= w_ad;
    end

    assign o_wr_en    = r_p5_vld;
    assign o_wr_addr  = r_p5_paddr;
    assign o_wr_data  = i_sel ? {r_p5_old, r_p5_new} : {r_p5_new, r_p5_old};
    assign o_residual = r_acc;
    assign o_busy     = r_s1_pos.vld || r_a_vld || r_b_vld || r_p1_vld || r_p2_vld ||
                        r_p3_vld || r_p4_vld || r_p5_vld || r_p6_vld;

    a_wr_follows_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p5_vld |-> $past(r_b_vld, 5))
        else $error("write-back without a matching window point");

    a_acc_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p6_vld && !i_start) |=> (r_acc >= $past(r_acc)))
        else $error("residual fell during a sweep");

    a_start_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !(r_p6_vld || r_p5_vld))
        else $error("sweep restarted with points still in flight");

endmodule

@@ sv/jacobi_poisson_grid_solver.sv @@
// ============================================================================
// jacobi_poisson_grid_solver: Jacobi solver for the 5-point Poisson stencil
// Loads a square Q4.28 grid and its source terms, runs Jacobi sweeps until
// the L1 change falls to the tolerance or the sweep limit, and reads points.
// ============================================================================
//
//  Channel   Direction  Handshake                    Payload
//  -------   ---------  ---------------------------  --------------------
//  in        sink       i_in_valid / o_in_ready      i_in_data  (t_in_item)
//  out       source     o_out_valid / i_out_ready    o_out_data (t_out_item)
//  cfg       sink       i_cfg_we (no wait)           i_cfg_index, i_cfg_wdata
//
//  A load is written as it is taken; a read waits in its read state until the
//  output register is free. During a solve the old copy is streamed out of the
//  grid RAM's single read port at one word per cycle, one extra row is read to
//  complete the bottom stencils, and the arithmetic pipeline must empty before
//  the residual is judged. Reset is synchronous and active low; it resets the
//  control state and the configuration registers but not the payload registers
//  or the RAMs. Output stalls hold the controller in its read or result state;
//  the input is refused until the current item is finished.
//
// The grid lives in one RAM whose word holds both copies side by side, so a
// write-back of a new value rewrites the unchanged old value with it. Source
// terms live in a second RAM that is written only by loads. During a sweep
// the controller issues one read per cycle in row-major order, running one
// row ahead of the point being computed; the stencil block rebuilds the
// up and centre values from two row buffers, the down value from the read
// data and the left and right values from a short shift line. No write can
// hit an address that is still to be read in the same sweep, and the next
// sweep only starts once the pipeline is empty, so no forwarding is needed.
// ============================================================================
module jacobi_poisson_grid_solver #(
    parameter int GRID_SIDE   = jps_pkg::GRID_SIDE_DEF,
    parameter int VALUE_WIDTH = jps_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  jps_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output jps_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [jps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [jps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import jps_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int NW    = $clog2(GRID_SIDE + 1);
    localparam int CNW   = 2 * NW;
    localparam logic signed [63:0] VMAX  = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [63:0] O32MAX = 64'sh0000_0000_7FFF_FFFF;

    // Configuration registers
    logic [SIDE_W-1:0]  r_side;
    logic [RES_W-1:0]   r_tol;
    logic [SWEEP_W-1:0] r_max_sw;

    // Controller state
    t_state             r_state, n_state;
    logic               r_sel;
    logic [SWEEP_W-1:0] r_sweeps, r_limit;
    logic               r_conv;
    logic [NW-1:0]      r_n;
    logic               r_rd_in;
    logic [AW-1:0]      r_rd_addr;

    // Sweep read issue counters
    logic [CW-1:0]      r_col;
    logic [NW-1:0]      r_row;
    logic [AW-1:0]      r_qaddr, r_paddr;

    // Output register
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [NW-1:0]      w_n;
    logic [CNW-1:0]     w_cells;
    logic               w_acc_in, w_in_grid, w_ld, w_out_free;
    logic               w_start, w_sweep_end, w_out_load;
    logic               w_conv, w_limit_hit, w_last_iss;
    t_pos               w_pos;
    logic [SWEEP_W-1:0] w_sweeps_inc;
    logic [VW-1:0]      w_ld_val, w_ld_src;
    logic signed [VW-1:0] w_rd_word;
    logic signed [31:0] w_rd_val;

    logic               w_g_we;
    logic [AW-1:0]      w_g_waddr, w_g_raddr;
    logic [2*VW-1:0]    w_g_wdata, w_g_rdata;
    logic [AW-1:0]      w_src_raddr;
    logic [VW-1:0]      w_src_rdata;

    logic               w_st_wr_en, w_busy;
    logic [AW-1:0]      w_st_wr_addr;
    logic [2*VW-1:0]    w_st_wr_data;
    logic [RES_W-1:0]   w_residual;

    // ------------------------------------------------------------------
    // Configuration writes. Indexes beyond the list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side   <= SIDE_RST;
            r_tol    <= TOL_RST;
            r_max_sw <= MAX_SW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SIDE:       r_side   <= i_cfg_wdata[SIDE_W-1:0];
                CFG_TOL:        r_tol    <= i_cfg_wdata[RES_W-1:0];
                CFG_MAX_SWEEPS: r_max_sw <= i_cfg_wdata[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // The side in use is the register clamped into the supported range.
    always_comb begin
        if (r_side < SIDE_MIN) begin
            w_n = NW'(3);
        end else if (int'(r_side) > GRID_SIDE) begin
            w_n = NW'(GRID_SIDE);
        end else begin
            w_n = NW'(r_side);
        end
        w_cells = CNW'(w_n) * CNW'(w_n);
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc_in   = i_in_valid && o_in_ready;
    assign w_in_grid  = 32'(i_in_data.point_index) < 32'(w_cells);
    assign w_ld       = w_acc_in && (i_in_data.kind == KIND_LOAD) && w_in_grid;
    assign w_ld_val   = VW'(clamp64(64'(i_in_data.start_value), VMAX));
    assign w_ld_src   = VW'(clamp64(64'(i_in_data.source_term), VMAX));
    assign w_out_free = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Sweep read issue: one row ahead of the point under computation.
    // The extra last row reads a harmless address; its data only feeds the
    // bottom edge, which keeps its value.
    // ------------------------------------------------------------------
    always_comb begin
        w_pos.vld       = (r_state == ST_SWEEP);
        w_pos.row_pre   = (r_row == '0);
        w_pos.row_top   = (r_row == NW'(1));
        w_pos.row_bot   = (r_row == r_n);
        w_pos.col_first = (r_col == '0);
        w_pos.col_last  = (r_col == CW'(r_n - NW'(1)));
        w_last_iss      = w_pos.vld && w_pos.row_bot && w_pos.col_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_col   <= '0;
            r_row   <= '0;
            r_qaddr <= '0;
            r_paddr <= '0;
        end else if (w_pos.vld) begin
            if (w_pos.col_last) begin
                r_col <= '0;
                r_row <= r_row + NW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
            r_qaddr <= r_qaddr + AW'(1);
            if (!w_pos.row_pre) begin
                r_paddr <= r_paddr + AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Grid and source RAMs
    // ------------------------------------------------------------------
    always_comb begin
        if (w_ld) begin
            w_g_we    = 1'b1;
            w_g_waddr = AW'(i_in_data.point_index);
            w_g_wdata = {w_ld_val, w_ld_val};
        end else begin
            w_g_we    = w_st_wr_en;
            w_g_waddr = w_st_wr_addr;
            w_g_wdata = w_st_wr_data;
        end
        if (r_state == ST_SWEEP) begin
            w_g_raddr = w_pos.row_bot ? '0 : r_qaddr;
        end else if (r_state == ST_READ) begin
            w_g_raddr = r_rd_addr;
        end else begin
            w_g_raddr = AW'(i_in_data.point_index);
        end
    end

    jps_ram #(.DEPTH(CELLS), .WIDTH(2 * VW)) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_g_we),
        .i_waddr (w_g_waddr),
        .i_wdata (w_g_wdata),
        .i_raddr (w_g_raddr),
        .o_rdata (w_g_rdata)
    );

    jps_ram #(.DEPTH(CELLS), .WIDTH(VW)) u_src (
        .i_clk   (i_clk),
        .i_we    (w_ld),
        .i_waddr (AW'(i_in_data.point_index)),
        .i_wdata (w_ld_src),
        .i_raddr (w_src_raddr),
        .o_rdata (w_src_rdata)
    );

    jps_stencil #(.GRID_SIDE(GRID_SIDE), .VALUE_WIDTH(VALUE_WIDTH)) u_stencil (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_pos        (w_pos),
        .i_col        (r_col),
        .i_paddr      (r_paddr),
        .i_sel        (r_sel),
        .i_grid_rdata (w_g_rdata),
        .o_src_raddr  (w_src_raddr),
        .i_src_rdata  (w_src_rdata),
        .o_wr_en      (w_st_wr_en),
        .o_wr_addr    (w_st_wr_addr),
        .o_wr_data    (w_st_wr_data),
        .o_busy       (w_busy),
        .o_residual   (w_residual)
    );

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign w_sweeps_inc = r_sweeps + SWEEP_W'(1);
    assign w_conv       = (w_residual <= r_tol);
    assign w_limit_hit  = (w_sweeps_inc >= r_limit);

    always_comb begin
        n_state     = r_state;
        w_start     = 1'b0;
        w_sweep_end = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    unique case (i_in_data.kind)
                        KIND_SOLVE: begin
                            n_state = ST_SWEEP;
                            w_start = 1'b1;
                        end
                        KIND_READ: n_state = ST_READ;
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (w_last_iss) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_busy) begin
                    w_sweep_end = 1'b1;
                    if (w_conv || w_limit_hit) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_SWEEP;
                        w_start = 1'b1;
                    end
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sel    <= 1'b0;
            r_sweeps <= '0;
            r_conv   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc_in && (i_in_data.kind == KIND_SOLVE)) begin
                r_sweeps <= '0;
            end else if (w_sweep_end) begin
                r_sweeps <= w_sweeps_inc;
                r_sel    <= ~r_sel;
                r_conv   <= w_conv;
            end
        end
    end

    // Solve and read parameters are captured when the item is taken.
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_n       <= w_n;
            r_limit   <= (r_max_sw == '0) ? SWEEP_W'(1) : r_max_sw;
            r_rd_in   <= w_in_grid;
            r_rd_addr <= AW'(i_in_data.point_index);
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    assign w_rd_word = r_sel ? w_g_rdata[2*VW-1:VW] : w_g_rdata[VW-1:0];
    assign w_rd_val  = r_rd_in ? 32'(clamp64(64'(w_rd_word), O32MAX)) : 32'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_state == ST_READ) begin
                r_out_data.read_value  <= w_rd_val;
                r_out_data.sweeps_done <= '0;
                r_out_data.converged   <= 1'b0;
                r_out_data.residual    <= '0;
            end else begin
                r_out_data.read_value  <= '0;
                r_out_data.sweeps_done <= r_sweeps;
                r_out_data.converged   <= r_conv;
                r_out_data.residual    <= w_residual;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_busy)
        else $error("input accepted while the stencil pipeline is busy");

    a_wr_in_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_st_wr_en |-> (r_state == ST_SWEEP || r_state == ST_DRAIN))
        else $error("stencil write-back outside a solve");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT) |-> (r_sweeps != '0 && r_sweeps <= r_limit))
        else $error("sweep count out of range at solve end");

    a_last_issue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_iss |=> (r_state == ST_DRAIN))
        else $error("sweep issue continued past the last row");

endmodule
